// ===== sv/bmf_pkg.sv =====
// Box mean filter package: default sizes, register indices, command and status types.
// No dependencies.
`default_nettype none
package bmf_pkg;

  localparam int unsigned DefMaxKernel = 7;
  localparam int unsigned DefMaxWidth  = 1024;
  localparam int unsigned DefMaxHeight = 1024;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 11;

  localparam logic [CfgIdxW-1:0] CFG_KERNEL = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_WIDTH  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_HEIGHT = 2'd2;

  typedef struct packed {
    logic take;
    logic rd_start;
    logic rd_step;
    logic acc;
    logic div_start;
    logic div_step;
    logic load;
  } bmf_cmd_t;

  typedef struct packed {
    logic produce;
    logic rd_last;
    logic div_done;
    logic out_free;
  } bmf_stat_t;

endpackage
`default_nettype wire

// ===== sv/box_mean_filter_core.sv =====
// Box mean filter top level: k-by-k box mean over a raster pixel stream.
// The window is k*k pixels for odd k and one pixel for zero or even k; the sum is S bits
// wide (14 at the default sizes). No new item is taken until a producing item's result is
// loaded into the output register. Window reads use the single line store read port.
// The divide is bit-serial. Reset sets the config defaults, clears the position counters
// and the output valid flag; the line store is written before it is read.
`default_nettype none
module box_mean_filter_core import bmf_pkg::*; #(
  parameter int unsigned MAX_KERNEL = DefMaxKernel,
  parameter int unsigned MAX_WIDTH  = DefMaxWidth,
  parameter int unsigned MAX_HEIGHT = DefMaxHeight
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  wire                 command_i,
  input  wire  [7:0]          in_pixel_i,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output logic [7:0]          out_pixel_o,
  output logic [9:0]          out_column_o,
  output logic [9:0]          out_row_o,
  output logic                frame_end_o,
  input  wire                 cfg_we_i,
  input  wire  [CfgIdxW-1:0]  cfg_index_i,
  input  wire  [CfgDataW-1:0] cfg_data_i
);

  bmf_cmd_t  cmd;
  bmf_stat_t stat;

  bmf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  bmf_datapath #(
    .MAX_KERNEL (MAX_KERNEL),
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .command_i    (command_i),
    .in_pixel_i   (in_pixel_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .out_pixel_o  (out_pixel_o),
    .out_column_o (out_column_o),
    .out_row_o    (out_row_o),
    .frame_end_o  (frame_end_o)
  );

  a_take_not_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.take |-> !cmd.load) else $error("accept and result load coincide");

  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |=> out_valid_o) else $error("loaded result not presented");

  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.rd_start |=> !in_ready_o) else $error("input taken during window read");

endmodule
`default_nettype wire

// ===== sv/bmf_ctrl.sv =====
// Box mean filter controller: sequences accept, window read, sum, divide and output load.
// Depends on bmf_pkg.
`default_nettype none
module bmf_ctrl import bmf_pkg::*; (
  input  wire       clk_i,
  input  wire       rst_ni,
  input  wire       in_valid_i,
  output logic      in_ready_o,
  input  bmf_stat_t stat_i,
  output bmf_cmd_t  cmd_o
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_READ   = 6'b000010,
    ST_ACC    = 6'b000100,
    ST_DSTART = 6'b001000,
    ST_DIV    = 6'b010000,
    ST_LOAD   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          if (stat_i.produce) begin
            cmd_o.rd_start = 1'b1;
            state_d        = ST_READ;
          end
        end
      end
      ST_READ: begin
        cmd_o.rd_step = 1'b1;
        if (stat_i.rd_last) state_d = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.acc = 1'b1;
        state_d   = ST_DSTART;
      end
      ST_DSTART: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_done) state_d = ST_LOAD;
      end
      ST_LOAD: begin
        if (stat_i.out_free) begin
          cmd_o.load = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

endmodule
`default_nettype wire

// ===== sv/bmf_datapath.sv =====
// Box mean filter datapath: position counters, line store, window sum, divider, output register.
// Depends on bmf_pkg.
`default_nettype none
module bmf_datapath import bmf_pkg::*; #(
  parameter int unsigned MAX_KERNEL = DefMaxKernel,
  parameter int unsigned MAX_WIDTH  = DefMaxWidth,
  parameter int unsigned MAX_HEIGHT = DefMaxHeight
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 command_i,
  input  wire  [7:0]          in_pixel_i,
  input  wire                 cfg_we_i,
  input  wire  [CfgIdxW-1:0]  cfg_index_i,
  input  wire  [CfgDataW-1:0] cfg_data_i,
  input  bmf_cmd_t            cmd_i,
  output bmf_stat_t           stat_o,
  input  wire                 out_ready_i,
  output logic                out_valid_o,
  output logic [7:0]          out_pixel_o,
  output logic [9:0]          out_column_o,
  output logic [9:0]          out_row_o,
  output logic                frame_end_o
);

  localparam int unsigned Depth = (MAX_KERNEL - 1) * MAX_WIDTH + MAX_KERNEL;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned KW    = $clog2(MAX_KERNEL + 1);
  localparam int unsigned OW    = $clog2(MAX_KERNEL / 2 + 1);
  localparam int unsigned IW    = $clog2(MAX_KERNEL);
  localparam int unsigned WW    = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW    = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned CLW   = $clog2(MAX_WIDTH);
  localparam int unsigned RW    = $clog2(MAX_HEIGHT);
  localparam int unsigned IRW   = $clog2(MAX_HEIGHT + MAX_KERNEL + 1);
  localparam int unsigned SW    = $clog2(MAX_KERNEL * MAX_KERNEL * 255 + 1);
  localparam int unsigned DVW   = $clog2(MAX_KERNEL * MAX_KERNEL + 1);
  localparam int unsigned DCW   = $clog2(SW + 1);
  localparam int unsigned XW    = AW + 2;
  localparam int unsigned QW    = IRW + WW;

  logic [2:0]          kreg_q;
  logic [CfgDataW-1:0] wreg_q, hreg_q;
  logic [KW-1:0]       keff;
  logic [WW-1:0]       weff;
  logic [HW-1:0]       heff;
  logic [OW-1:0]       off;
  logic [IW-1:0]       kk_m1;
  logic [DVW-1:0]      divisor;
  logic [XW-1:0]       lag, start_x, step_x, step_mod, next_x;
  logic [QW-1:0]       qpos;
  logic                restart;

  logic [CLW-1:0] icol_q, ocol_q;
  logic [IRW-1:0] irow_q;
  logic [RW-1:0]  orow_q;
  logic [AW-1:0]  wptr_q, optr_q, raddr_q;
  logic [IW-1:0]  i_q, j_q;
  logic [7:0]     mem [Depth];
  logic [7:0]     rdata_q;
  logic           rv_q;
  logic [SW-1:0]  sum_q, quo_q;
  logic [DVW-1:0] rem_q;
  logic [DCW-1:0] dcnt_q;
  logic [DVW:0]   trial;
  logic           ignore, inrange, last_pix;
  logic [RW+IW:0]  rsum;
  logic [CLW+IW:0] csum;

  always_comb begin
    keff    = (32'(kreg_q) > MAX_KERNEL) ? KW'(MAX_KERNEL) : KW'(kreg_q);
    weff    = (wreg_q == '0) ? WW'(1) :
              (32'(wreg_q) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(wreg_q);
    heff    = (hreg_q == '0) ? HW'(1) :
              (32'(hreg_q) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(hreg_q);
    off     = keff[0] ? OW'(keff >> 1) : '0;
    kk_m1   = IW'({off, 1'b0});
    divisor = keff[0] ? DVW'(keff * keff) : DVW'(1);
    lag     = XW'(off * weff) + XW'(off);
    qpos    = QW'(irow_q) * QW'(weff) + QW'(icol_q);
    start_x = XW'(optr_q) + XW'(Depth) - lag;
    if (start_x >= XW'(Depth)) start_x = start_x - XW'(Depth);
    step_mod = XW'(weff) + XW'(Depth) - XW'({off, 1'b0});
    if (step_mod >= XW'(Depth)) step_mod = step_mod - XW'(Depth);
    step_x  = (j_q == kk_m1) ? step_mod : XW'(1);
    next_x  = XW'(raddr_q) + step_x;
    if (next_x >= XW'(Depth)) next_x = next_x - XW'(Depth);
    ignore  = command_i && irow_q == '0 && icol_q == '0;
    rsum    = (RW+IW+1)'(orow_q) + (RW+IW+1)'(i_q);
    csum    = (CLW+IW+1)'(ocol_q) + (CLW+IW+1)'(j_q);
    inrange = 32'(rsum) >= 32'(off) && 32'(rsum) < 32'(heff) + 32'(off) &&
              32'(csum) >= 32'(off) && 32'(csum) < 32'(weff) + 32'(off);
    trial   = {rem_q, quo_q[SW-1]};
    last_pix = 32'(orow_q) + 1 >= 32'(heff) && 32'(ocol_q) + 1 >= 32'(weff);
    restart = cfg_we_i && (cfg_index_i == CFG_KERNEL || cfg_index_i == CFG_WIDTH ||
                           cfg_index_i == CFG_HEIGHT);
  end

  always_comb begin
    stat_o.produce  = !ignore && qpos >= QW'(lag);
    stat_o.rd_last  = i_q == kk_m1 && j_q == kk_m1;
    stat_o.div_done = dcnt_q == DCW'(SW - 1);
    stat_o.out_free = !out_valid_o || out_ready_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kreg_q <= 3'd3;
      wreg_q <= CfgDataW'(1024);
      hreg_q <= CfgDataW'(1024);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_KERNEL: kreg_q <= cfg_data_i[2:0];
        CFG_WIDTH:  wreg_q <= cfg_data_i;
        CFG_HEIGHT: hreg_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      icol_q <= '0;
      irow_q <= '0;
      ocol_q <= '0;
      orow_q <= '0;
      wptr_q <= '0;
      optr_q <= '0;
    end else if (restart || (cmd_i.load && last_pix)) begin
      icol_q <= '0;
      irow_q <= '0;
      ocol_q <= '0;
      orow_q <= '0;
      wptr_q <= '0;
      optr_q <= '0;
    end else begin
      if (cmd_i.take && !ignore) begin
        wptr_q <= (32'(wptr_q) == Depth - 1) ? '0 : wptr_q + AW'(1);
        if (32'(icol_q) + 1 >= 32'(weff)) begin
          icol_q <= '0;
          irow_q <= irow_q + IRW'(1);
        end else begin
          icol_q <= icol_q + CLW'(1);
        end
      end
      if (cmd_i.load) begin
        optr_q <= (32'(optr_q) == Depth - 1) ? '0 : optr_q + AW'(1);
        if (32'(ocol_q) + 1 >= 32'(weff)) begin
          ocol_q <= '0;
          orow_q <= orow_q + RW'(1);
        end else begin
          ocol_q <= ocol_q + CLW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take && !ignore && 32'(irow_q) < 32'(heff)) begin
      mem[wptr_q] <= command_i ? 8'd0 : in_pixel_i;
    end
    if (cmd_i.rd_step) begin
      rdata_q <= mem[raddr_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_start) begin
      raddr_q <= AW'(start_x);
      i_q     <= '0;
      j_q     <= '0;
      sum_q   <= '0;
      rv_q    <= 1'b0;
    end else if (cmd_i.rd_step) begin
      rv_q    <= inrange;
      sum_q   <= sum_q + (rv_q ? SW'(rdata_q) : '0);
      raddr_q <= AW'(next_x);
      if (j_q == kk_m1) begin
        j_q <= '0;
        i_q <= i_q + IW'(1);
      end else begin
        j_q <= j_q + IW'(1);
      end
    end else if (cmd_i.acc) begin
      sum_q <= sum_q + (rv_q ? SW'(rdata_q) : '0);
    end
    if (cmd_i.div_start) begin
      rem_q  <= '0;
      quo_q  <= sum_q;
      dcnt_q <= '0;
    end else if (cmd_i.div_step) begin
      dcnt_q <= dcnt_q + DCW'(1);
      if (trial >= {1'b0, divisor}) begin
        rem_q <= DVW'(trial - {1'b0, divisor});
        quo_q <= {quo_q[SW-2:0], 1'b1};
      end else begin
        rem_q <= trial[DVW-1:0];
        quo_q <= {quo_q[SW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)              out_valid_o <= 1'b0;
    else if (cmd_i.load)      out_valid_o <= 1'b1;
    else if (out_ready_i)     out_valid_o <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_pixel_o  <= quo_q[7:0];
      out_column_o <= 10'(ocol_q);
      out_row_o    <= 10'(orow_q);
      frame_end_o  <= last_pix;
    end
  end

endmodule
`default_nettype wire
